### sv/nps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package nps_pkg;

  // table and coordinate sizes
  localparam int MAX_POINTS = 1024;
  localparam int COORD_W    = 24;

  // derived widths
  localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W   = 2 * COORD_W + 1;
  localparam int DIST_W = SQ_W + 2;

  // fixed field widths of the item formats
  localparam int IDX_W       = 10;
  localparam int PC_W        = 11;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 16;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_POINT_COUNT = 3'd0;

  // item kind carried on tuser
  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  // one stored point
  typedef struct packed {
    logic                      flag;
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  // read request issued by the sequencer
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] idx;
  } tag_t;

  // distance of one scanned point
  typedef struct packed {
    logic              vld;
    logic [ADDR_W-1:0] idx;
    logic              flag;
    logic [DIST_W-1:0] sqdist;
  } dist_res_t;

endpackage
`default_nettype wire

### sv/nps_point_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module nps_point_mem (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [nps_pkg::ADDR_W-1:0] wr_addr,
  input  wire nps_pkg::point_t       wr_data,
  input  wire nps_pkg::tag_t         rd_req,
  output nps_pkg::point_t            rd_data
);
  import nps_pkg::*;

  point_t mem [MAX_POINTS];
  point_t rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_req.vld) begin
      rd_data_r <= mem[rd_req.idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

### sv/nps_dist_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module nps_dist_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_load,
  input  wire logic signed [nps_pkg::COORD_W-1:0] q_x,
  input  wire logic signed [nps_pkg::COORD_W-1:0] q_y,
  input  wire logic signed [nps_pkg::COORD_W-1:0] q_z,
  input  wire nps_pkg::tag_t                 req,
  input  wire nps_pkg::point_t               pt,
  output nps_pkg::dist_res_t                 res,
  output logic                               busy
);
  import nps_pkg::*;

  logic signed [COORD_W-1:0] qx_r, qy_r, qz_r;

  // stage a: lines up with the memory read
  logic              a_vld_r;
  logic [ADDR_W-1:0] a_idx_r;
  // stage b: differences
  logic              b_vld_r, b_flag_r;
  logic [ADDR_W-1:0] b_idx_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dz_r;
  // stage c: squares
  logic              c_vld_r, c_flag_r;
  logic [ADDR_W-1:0] c_idx_r;
  logic [SQ_W-1:0]   sx_r, sy_r, sz_r;
  // stage d: sum
  logic              d_vld_r, d_flag_r;
  logic [ADDR_W-1:0] d_idx_r;
  logic [DIST_W-1:0] dist_r;

  logic signed [2*DIFF_W-1:0] px, py, pz;

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  // valid bits of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
    end else begin
      a_vld_r <= req.vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
      d_vld_r <= c_vld_r;
    end
  end

  // query position and datapath registers
  always_ff @(posedge clk) begin
    if (q_load) begin
      qx_r <= q_x;
      qy_r <= q_y;
      qz_r <= q_z;
    end
    a_idx_r  <= req.idx;
    b_idx_r  <= a_idx_r;
    b_flag_r <= pt.flag;
    dx_r     <= DIFF_W'(qx_r) - DIFF_W'(pt.x);
    dy_r     <= DIFF_W'(qy_r) - DIFF_W'(pt.y);
    dz_r     <= DIFF_W'(qz_r) - DIFF_W'(pt.z);
    c_idx_r  <= b_idx_r;
    c_flag_r <= b_flag_r;
    sx_r     <= px[SQ_W-1:0];
    sy_r     <= py[SQ_W-1:0];
    sz_r     <= pz[SQ_W-1:0];
    d_idx_r  <= c_idx_r;
    d_flag_r <= c_flag_r;
    dist_r   <= DIST_W'(sx_r) + DIST_W'(sy_r) + DIST_W'(sz_r);
  end

  assign res.vld    = d_vld_r;
  assign res.idx    = d_idx_r;
  assign res.flag   = d_flag_r;
  assign res.sqdist = dist_r;
  assign busy       = a_vld_r | b_vld_r | c_vld_r | d_vld_r;

endmodule
`default_nettype wire

### sv/nps_seq.sv
`timescale 1ns / 1ps
`default_nettype none
module nps_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [nps_pkg::CNT_W-1:0]   count,
  input  wire logic                        surface_only,
  output nps_pkg::tag_t                    req,
  input  wire nps_pkg::dist_res_t          res,
  input  wire logic                        busy,
  output logic                             idle,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [nps_pkg::IDX_W-1:0]        out_index,
  output logic                             out_found
);
  import nps_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              sonly_r, sonly_nxt;
  logic              have_r, have_nxt;
  logic [ADDR_W-1:0] best_idx_r, best_idx_nxt;
  logic [DIST_W-1:0] best_dist_r, best_dist_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;
  logic              out_found_r, out_found_nxt;
  logic              take;

  // a scanned point that passes the filter and beats the best so far
  assign take = res.vld && (!sonly_r || res.flag) &&
                (!have_r || (res.sqdist < best_dist_r));

  assign req.vld = (state_r == S_SCAN) && (cnt_r < n_r);
  assign req.idx = cnt_r[ADDR_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    sonly_nxt     = sonly_r;
    have_nxt      = have_r;
    best_idx_nxt  = best_idx_r;
    best_dist_nxt = best_dist_r;
    out_valid_nxt = out_valid_r;
    out_index_nxt = out_index_r;
    out_found_nxt = out_found_r;

    // result register empties on handshake
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // running minimum, first one kept on ties
    if (take) begin
      have_nxt      = 1'b1;
      best_idx_nxt  = res.idx;
      best_dist_nxt = res.sqdist;
    end

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_SCAN;
          cnt_nxt   = '0;
          have_nxt  = 1'b0;
          sonly_nxt = surface_only;
          n_nxt     = (32'(count) > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count;
        end
      end
      S_SCAN: begin
        if (cnt_r < n_r) begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = have_r;
          out_index_nxt = have_r ? IDX_W'(best_idx_r) : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      n_r         <= '0;
      sonly_r     <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      sonly_r     <= sonly_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
    best_idx_r  <= best_idx_nxt;
    best_dist_r <= best_dist_nxt;
    out_index_r <= out_index_nxt;
    out_found_r <= out_found_nxt;
  end

  assign idle      = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_found = out_found_r;

endmodule
`default_nettype wire

### sv/nearest_point_search.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake            payload
// in_       slave      in_tvalid/in_tready  in_tdata, in_tuser (store or query)
// out_      master     out_tvalid/out_tready out_tdata (nearest index, found)
// cfg_      apb slave  psel/penable/pready  point_count at byte address 0
//
// a store item is accepted whenever the input is ready and writes the point table at once
// a query scans min(point_count, 1024) entries at one per cycle, then drains the
// distance pipeline before the input is ready again
// the input is not ready during a query; a result blocked on out_tready holds the
// next query in its last step until the output register is free
// reset is synchronous, active low; the point table itself is not cleared
module nearest_point_search (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // slot_index[9:0], coord_x[33:10], coord_y[57:34], coord_z[81:58],
  // surface_mark[82], surface_only[83], zero[87:84]
  input  wire logic [nps_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation[0]
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // nearest_index[9:0], found[10], zero[15:11]
  output logic [nps_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                              cfg_psel,
  input  wire logic                              cfg_penable,
  input  wire logic                              cfg_pwrite,
  input  wire logic [nps_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [31:0]                       cfg_pwdata,
  output logic [31:0]                            cfg_prdata,
  output logic                                   cfg_pready
);
  import nps_pkg::*;

  logic [PC_W-1:0]    point_count_r;
  logic               accept, is_store, is_query, seq_idle;
  logic [IDX_W-1:0]   slot_index;
  logic               surface_mark, surface_only;
  logic signed [COORD_W-1:0] coord_x, coord_y, coord_z;
  point_t             wr_pt, rd_pt;
  tag_t               req;
  dist_res_t          res;
  logic               busy;
  logic [IDX_W-1:0]   nearest_index;
  logic               found;

  // field unpacking
  assign slot_index   = in_tdata[9:0];
  assign coord_x      = in_tdata[33:10];
  assign coord_y      = in_tdata[57:34];
  assign coord_z      = in_tdata[81:58];
  assign surface_mark = in_tdata[82];
  assign surface_only = in_tdata[83];

  assign in_tready = seq_idle;
  assign accept    = in_tvalid && in_tready;
  assign is_store  = accept && (in_tuser == OP_STORE);
  assign is_query  = accept && (in_tuser == OP_QUERY);

  // configuration register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == REG_POINT_COUNT)) begin
      point_count_r <= cfg_pwdata[PC_W-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == REG_POINT_COUNT) ? 32'(point_count_r) : '0;

  assign wr_pt.x    = coord_x;
  assign wr_pt.y    = coord_y;
  assign wr_pt.z    = coord_z;
  assign wr_pt.flag = surface_mark;

  nps_point_mem u_mem (
    .clk     (clk),
    .wr_en   (is_store && (32'(slot_index) < 32'(MAX_POINTS))),
    .wr_addr (ADDR_W'(slot_index)),
    .wr_data (wr_pt),
    .rd_req  (req),
    .rd_data (rd_pt)
  );

  nps_dist_unit u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_load (is_query),
    .q_x    (coord_x),
    .q_y    (coord_y),
    .q_z    (coord_z),
    .req    (req),
    .pt     (rd_pt),
    .res    (res),
    .busy   (busy)
  );

  nps_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (is_query),
    .count        (CNT_W'(point_count_r)),
    .surface_only (surface_only),
    .req          (req),
    .res          (res),
    .busy         (busy),
    .idle         (seq_idle),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_index    (nearest_index),
    .out_found    (found)
  );

  assign out_tdata = {(OUT_TDATA_W - IDX_W - 1)'(0), found, nearest_index};

endmodule
`default_nettype wire

### sv/nps_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module nps_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [nps_pkg::IN_TDATA_W-1:0] in_tdata,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [nps_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import nps_pkg::*;

  // a query blocks the input while it runs
  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_QUERY) |=> !in_tready)
    else $error("input still ready after a query item");

  // a store item never blocks the next one
  a_store_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == OP_STORE) |=> in_tready)
    else $error("input not ready after a store item");

  // a not-found result reports index zero
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[IDX_W] |-> (out_tdata[IDX_W-1:0] == '0))
    else $error("nonzero index on a not-found result");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // pad bits of the result stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:IDX_W+1] == '0))
    else $error("result pad bits not zero");

endmodule

bind nearest_point_search nps_checker u_nps_checker (.*);
`default_nettype wire
